@@ sv/assert_macros.svh @@
// assertion helpers used by jcp_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define JCP_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked out of reset
`define JCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/jcp_pkg.sv @@
`default_nettype none

package jcp_pkg;

   localparam int CMD_BITS   = 24;
   localparam int REPLY_BITS = 61;
   localparam int GROUP_BITS = 9;

   localparam logic [CMD_BITS-1:0] POLL_COMMAND = 24'h400300;

   localparam int BIT_TICKS_W = 10;
   localparam int LOW_TICKS_W = 10;
   localparam int FIRST_W     = 12;
   localparam int RESYNC_W    = 8;
   localparam int TICK_W      = 12;
   localparam int IDX_W       = 7;
   localparam int GRP_W       = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RST  = 10'd200;
   localparam logic [LOW_TICKS_W-1:0] ZERO_LOW_RST   = 10'd150;
   localparam logic [LOW_TICKS_W-1:0] ONE_LOW_RST    = 10'd50;
   localparam logic [FIRST_W-1:0]     FIRST_RST      = 12'd1240;
   localparam logic [RESYNC_W-1:0]    RESYNC_RST     = 8'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIT_TICKS    = 3'd0,
      CSR_ZERO_LOW     = 3'd1,
      CSR_ONE_LOW      = 3'd2,
      CSR_FIRST_SAMPLE = 3'd3,
      CSR_RESYNC       = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_RECV = 2'd2
   } phase_type;

   typedef struct packed {
      logic start_req;
      logic port_select;
      logic rumble;
      logic line_in_one;
      logic line_in_two;
   } req_type;

   typedef struct packed {
      logic                  drive_low_one;
      logic                  drive_low_two;
      logic                  busy_res;
      logic                  done_res;
      logic [REPLY_BITS-1:0] reply_word;
   } rsp_type;

   typedef struct packed {
      logic [BIT_TICKS_W-1:0] bit_ticks;
      logic [LOW_TICKS_W-1:0] zero_low_ticks;
      logic [LOW_TICKS_W-1:0] one_low_ticks;
      logic [FIRST_W-1:0]     first_sample_ticks;
      logic [RESYNC_W-1:0]    resync_ticks;
   } cfg_type;

endpackage

`default_nettype wire

@@ sv/joybus_controller_poller.sv @@
// channel  ports                                   word
// req      req_valid, req_stall, req_data          one line tick: start, port, rumble, levels
// rsp      rsp_valid, rsp_stall, rsp_data          drives, busy, done, reply word
// csr      csr_valid, csr_ready, csr_index, csr_data  timing register write
//
// one req word per cycle while req_stall is low; its rsp word is held in the output register
// the poll state advances once per accepted req word, all in one combinational step
// reset is synchronous; it restores the timing registers and returns the poller to idle
// req_stall rises only while an rsp word is held and rsp_stall is high
// csr_ready is always high; a write takes effect for the next req word
`default_nettype none

module joybus_controller_poller
   import jcp_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  req_type         req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output rsp_type               rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;
   rsp_type result;
   logic    in_accept;

   jcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   jcp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .item      (req_data),
      .cfg       (cfg),
      .result    (result)
   );

   jcp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .in_accept (in_accept),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ sv/jcp_csr.sv @@
`default_nettype none

module jcp_csr
   import jcp_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_BIT_TICKS:    cfg_in.bit_ticks          = csr_data[BIT_TICKS_W-1:0];
            CSR_ZERO_LOW:     cfg_in.zero_low_ticks     = csr_data[LOW_TICKS_W-1:0];
            CSR_ONE_LOW:      cfg_in.one_low_ticks      = csr_data[LOW_TICKS_W-1:0];
            CSR_FIRST_SAMPLE: cfg_in.first_sample_ticks = csr_data[FIRST_W-1:0];
            CSR_RESYNC:       cfg_in.resync_ticks       = csr_data[RESYNC_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks          <= BIT_TICKS_RST;
         cfg_ff.zero_low_ticks     <= ZERO_LOW_RST;
         cfg_ff.one_low_ticks      <= ONE_LOW_RST;
         cfg_ff.first_sample_ticks <= FIRST_RST;
         cfg_ff.resync_ticks       <= RESYNC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/jcp_engine.sv @@
`default_nettype none
`include "assert_macros.svh"

module jcp_engine
   import jcp_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           in_accept,
   input  wire req_type  item,
   input  wire cfg_type  cfg,
   output rsp_type       result
);

   phase_type              phase_ff, phase_in;
   logic                   port_ff, port_in;
   logic [CMD_BITS:0]      cmd_ff, cmd_in;
   logic [IDX_W-1:0]       bit_ff, bit_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [GRP_W-1:0]       grp_ff, grp_in;
   logic [REPLY_BITS-1:0]  reply_ff, reply_in;

   phase_type              phase_v;
   logic [CMD_BITS:0]      cmd_v;
   logic [IDX_W-1:0]       bit_v;
   logic [TICK_W-1:0]      tick_v;
   logic [GRP_W-1:0]       grp_v;
   logic [REPLY_BITS-1:0]  reply_v;
   logic [BIT_TICKS_W-1:0] period;
   logic [LOW_TICKS_W-1:0] low;
   logic [TICK_W-1:0]      tick_inc;
   logic [GRP_W-1:0]       grp_inc;
   logic                   level;
   logic                   drive;

   always_comb begin
      phase_v = phase_ff;
      port_in = port_ff;
      cmd_v   = cmd_ff;
      bit_v   = bit_ff;
      tick_v  = tick_ff;
      grp_v   = grp_ff;
      reply_v = reply_ff;
      period  = (cfg.bit_ticks == '0) ? BIT_TICKS_W'(1) : cfg.bit_ticks;
      low     = '0;
      tick_inc = '0;
      grp_inc  = '0;
      level    = 1'b0;
      drive    = 1'b0;
      result   = '0;

      // the start tick is already the first tick of the first command bit
      if (phase_ff == PH_IDLE && item.start_req) begin
         port_in = item.port_select;
         cmd_v   = {POLL_COMMAND[CMD_BITS-1:1], POLL_COMMAND[0] | item.rumble, 1'b1};
         bit_v   = '0;
         tick_v  = '0;
         grp_v   = '0;
         reply_v = '0;
         phase_v = PH_SEND;
      end

      phase_in = phase_v;
      cmd_in   = cmd_v;
      bit_in   = bit_v;
      tick_in  = tick_v;
      grp_in   = grp_v;
      reply_in = reply_v;

      case (phase_v)
         PH_SEND: begin
            result.busy_res = 1'b1;
            low      = cmd_v[CMD_BITS] ? cfg.one_low_ticks : cfg.zero_low_ticks;
            drive    = tick_v < TICK_W'(low);
            tick_inc = tick_v + TICK_W'(1);
            if (tick_inc >= TICK_W'(period)) begin
               tick_in = '0;
               cmd_in  = {cmd_v[CMD_BITS-1:0], 1'b0};
               if (bit_v == IDX_W'(CMD_BITS)) begin
                  // stop bit sent, load delay to first sample
                  bit_in   = '0;
                  tick_in  = (cfg.first_sample_ticks == '0) ? '0 :
                             TICK_W'(cfg.first_sample_ticks - FIRST_W'(1));
                  phase_in = PH_RECV;
               end else begin
                  bit_in = bit_v + IDX_W'(1);
               end
            end else begin
               tick_in = tick_inc;
            end
         end
         PH_RECV: begin
            result.busy_res = 1'b1;
            if (tick_v != '0) begin
               tick_in = tick_v - TICK_W'(1);
            end else begin
               level    = port_in ? item.line_in_two : item.line_in_one;
               reply_in = {reply_v[REPLY_BITS-2:0], level};
               if (bit_v == IDX_W'(REPLY_BITS - 1)) begin
                  result.done_res   = 1'b1;
                  result.reply_word = reply_in;
                  bit_in   = '0;
                  grp_in   = '0;
                  phase_in = PH_IDLE;
               end else begin
                  bit_in  = bit_v + IDX_W'(1);
                  tick_in = (cfg.bit_ticks == '0) ? '0 :
                            TICK_W'(cfg.bit_ticks - BIT_TICKS_W'(1));
                  grp_inc = grp_v + GRP_W'(1);
                  grp_in  = grp_inc;
                  if (grp_inc >= GRP_W'(GROUP_BITS)) begin
                     grp_in  = '0;
                     tick_in = tick_in + TICK_W'(cfg.resync_ticks);
                  end
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      result.drive_low_one = drive & ~port_in;
      result.drive_low_two = drive & port_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         port_ff  <= 1'b0;
         cmd_ff   <= '0;
         bit_ff   <= '0;
         tick_ff  <= '0;
         grp_ff   <= '0;
         reply_ff <= '0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         port_ff  <= port_in;
         cmd_ff   <= cmd_in;
         bit_ff   <= bit_in;
         tick_ff  <= tick_in;
         grp_ff   <= grp_in;
         reply_ff <= reply_in;
      end
   end

   `JCP_ASSERT_NEXT(a_done_to_idle, clock, reset, in_accept && result.done_res, phase_ff == PH_IDLE)
   `JCP_ASSERT(a_send_index, clock, reset, phase_ff == PH_SEND, bit_ff <= IDX_W'(CMD_BITS))
   `JCP_ASSERT(a_group_range, clock, reset, phase_ff == PH_RECV, grp_ff < GRP_W'(GROUP_BITS))

endmodule

`default_nettype wire

@@ sv/jcp_out_reg.sv @@
`default_nettype none

module jcp_out_reg
   import jcp_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   output logic          in_accept,
   input  wire rsp_type  result,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output rsp_type       rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // word moves on when the output slot is empty or being drained
   assign req_stall = valid_ff & rsp_stall;
   assign in_accept = req_valid & ~req_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff & rsp_stall;
      data_in  = data_ff;
      if (in_accept) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jcp_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned REPORT_MAX  = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // stimulus side
   req_type     ticks_to_send[$];
   logic        req_took = 1'b0;
   logic        send_hold = 1'b0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   // poller prediction state
   rsp_type               outputs_due[$];
   cfg_type               timing;
   phase_type             sim_phase;
   logic                  sim_port;
   logic [CMD_BITS:0]     sim_cmd;
   int unsigned           sim_bits;
   int unsigned           sim_wait;
   int unsigned           sim_group;
   logic [REPLY_BITS-1:0] sim_reply;
   int unsigned           polls_done = 0;
   int unsigned           faults = 0;

   joybus_controller_poller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // one line tick of the poll engine
   task automatic poller_tick(input req_type t, output rsp_type r);
      logic        drive;
      int unsigned period;
      int unsigned low;
      drive = 1'b0;
      r = '0;
      if (sim_phase == PH_IDLE && t.start_req) begin
         sim_port  = t.port_select;
         sim_cmd   = {POLL_COMMAND[CMD_BITS-1:1], POLL_COMMAND[0] | t.rumble, 1'b1};
         sim_bits  = 0;
         sim_wait  = 0;
         sim_group = 0;
         sim_reply = '0;
         sim_phase = PH_SEND;
      end
      if (sim_phase == PH_SEND) begin
         period = (timing.bit_ticks != '0) ? 32'(timing.bit_ticks) : 32'd1;
         low = sim_cmd[CMD_BITS] ? 32'(timing.one_low_ticks) : 32'(timing.zero_low_ticks);
         r.busy_res = 1'b1;
         drive = (sim_wait < low);
         sim_wait++;
         if (sim_wait >= period) begin
            sim_wait = 0;
            sim_cmd  = sim_cmd << 1;
            sim_bits++;
            if (sim_bits >= CMD_BITS + 1) begin
               sim_bits  = 0;
               sim_wait  = (timing.first_sample_ticks != '0) ?
                           32'(timing.first_sample_ticks) - 32'd1 : 32'd0;
               sim_phase = PH_RECV;
            end
         end
      end else if (sim_phase == PH_RECV) begin
         r.busy_res = 1'b1;
         if (sim_wait > 0) begin
            sim_wait--;
         end else begin
            sim_reply = {sim_reply[REPLY_BITS-2:0], sim_port ? t.line_in_two : t.line_in_one};
            sim_bits++;
            if (sim_bits >= REPLY_BITS) begin
               r.done_res   = 1'b1;
               r.reply_word = sim_reply;
               sim_bits     = 0;
               sim_group    = 0;
               sim_phase    = PH_IDLE;
               polls_done++;
            end else begin
               sim_wait = (timing.bit_ticks != '0) ? 32'(timing.bit_ticks) - 32'd1 : 32'd0;
               sim_group++;
               // resync gap after each group of samples
               if (sim_group >= GROUP_BITS) begin
                  sim_group = 0;
                  sim_wait += 32'(timing.resync_ticks);
               end
            end
         end
      end
      r.drive_low_one = !sim_port && drive;
      r.drive_low_two = sim_port && drive;
   endtask

   task automatic check_field(input string label, input logic [REPLY_BITS-1:0] want,
                              input logic [REPLY_BITS-1:0] got);
      if (got !== want) begin
         faults++;
         if (faults <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
      end
   endtask

   // driver: a word stays put until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (!send_hold && ticks_to_send.size() != 0 &&
             $urandom_range(99, 0) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= ticks_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with a long hold-off whenever hold_toggle flips
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type got;
      req_took <= !reset && req_valid && !req_stall;
      if (reset) begin
         timing    = '{BIT_TICKS_RST, ZERO_LOW_RST, ONE_LOW_RST, FIRST_RST, RESYNC_RST};
         sim_phase = PH_IDLE;
         sim_port  = 1'b0;
         sim_cmd   = '0;
         sim_bits  = 0;
         sim_wait  = 0;
         sim_group = 0;
         sim_reply = '0;
         outputs_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            poller_tick(req_data, want);
            outputs_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (outputs_due.size() == 0) begin
               faults++;
               if (faults <= REPORT_MAX)
                  $display("%0t: unexpected word %h", $time, got);
            end else begin
               want = outputs_due.pop_front();
               check_field("drive_low_one", REPLY_BITS'(want.drive_low_one),
                           REPLY_BITS'(got.drive_low_one));
               check_field("drive_low_two", REPLY_BITS'(want.drive_low_two),
                           REPLY_BITS'(got.drive_low_two));
               check_field("busy_res", REPLY_BITS'(want.busy_res), REPLY_BITS'(got.busy_res));
               check_field("done_res", REPLY_BITS'(want.done_res), REPLY_BITS'(got.done_res));
               check_field("reply_word", want.reply_word, got.reply_word);
            end
         end
         // a register write counts from the next word on
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BIT_TICKS:    timing.bit_ticks          = csr_data[BIT_TICKS_W-1:0];
               CSR_ZERO_LOW:     timing.zero_low_ticks     = csr_data[LOW_TICKS_W-1:0];
               CSR_ONE_LOW:      timing.one_low_ticks      = csr_data[LOW_TICKS_W-1:0];
               CSR_FIRST_SAMPLE: timing.first_sample_ticks = csr_data[FIRST_W-1:0];
               CSR_RESYNC:       timing.resync_ticks       = csr_data[RESYNC_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // upper data bits beyond the register width get random junk
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      int unsigned width;
      case (idx)
         CSR_BIT_TICKS:    width = BIT_TICKS_W;
         CSR_ZERO_LOW:     width = LOW_TICKS_W;
         CSR_ONE_LOW:      width = LOW_TICKS_W;
         CSR_FIRST_SAMPLE: width = FIRST_W;
         CSR_RESYNC:       width = RESYNC_W;
         default:          width = 0;
      endcase
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value | ($urandom << width));
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_timing(input int unsigned bit_t, input int unsigned zero_t,
                                 input int unsigned one_t, input int unsigned first_t,
                                 input int unsigned resync_t);
      write_reg(CSR_BIT_TICKS, bit_t);
      write_reg(CSR_ZERO_LOW, zero_t);
      write_reg(CSR_ONE_LOW, one_t);
      write_reg(CSR_FIRST_SAMPLE, first_t);
      write_reg(CSR_RESYNC, resync_t);
   endtask

   function automatic req_type random_tick(input int unsigned start_pct);
      req_type t;
      t = req_type'(5'($urandom_range(31, 0)));
      t.start_req = ($urandom_range(99, 0) < start_pct);
      return t;
   endfunction

   // keep the queue topped up until enough ticks and polls have gone through
   task automatic feed_ticks(input int unsigned min_ticks, input int unsigned min_polls);
      int unsigned sent;
      int unsigned base;
      sent = 0;
      base = polls_done;
      while (sent < min_ticks || polls_done - base < min_polls) begin
         while (ticks_to_send.size() > 8) @(posedge clock);
         ticks_to_send.push_back(random_tick(20));
         sent++;
      end
   endtask

   task automatic drain();
      while (ticks_to_send.size() != 0 || req_valid || outputs_due.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      int      k;
      req_type first;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 14;
      receiver_idle_pct = 88;

      // zero bit period, zero first delay, zero pulse longer than the period,
      // no pulse for a one
      program_timing(0, 1023, 0, 0, 12);
      write_reg(CSR_UNMAPPED, $urandom_range(4095, 0));
      first = '0;
      first.start_req   = 1'b1;
      first.port_select = 1'b1;
      first.rumble      = 1'b1;
      ticks_to_send.push_back(first);
      // starts in here land while busy
      for (k = 0; k < 23; k++) ticks_to_send.push_back(req_type'(k[4:0]));
      feed_ticks(60, 1);
      drain();

      program_timing($urandom_range(3, 2), $urandom_range(4, 1), $urandom_range(4, 1),
                     $urandom_range(4, 1), $urandom_range(2, 0));
      feed_ticks(100, 1);
      drain();

      sender_idle_pct   = 88;
      receiver_idle_pct = 14;
      program_timing($urandom_range(3, 2), $urandom_range(4, 1), $urandom_range(4, 1),
                     $urandom_range(4, 1), $urandom_range(2, 0));
      feed_ticks(100, 1);
      drain();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      program_timing($urandom_range(3, 2), $urandom_range(4, 1), $urandom_range(4, 1),
                     $urandom_range(4, 1), $urandom_range(2, 0));
      hold_toggle = ~hold_toggle;
      feed_ticks(100, 0);
      send_hold = 1'b1;
      while (req_valid || outputs_due.size() != 0) @(posedge clock);
      send_hold = 1'b0;
      feed_ticks(50, 0);
      drain();

      // slowest bit period, only the first ticks of a bit
      program_timing(1023, 1023, 1, 1, 0);
      feed_ticks(30, 0);
      drain();

      // pulse for a one longer than the period, longest first delay
      program_timing(2, 1, 1023, 4095, 255);
      feed_ticks(70, 0);
      drain();

      repeat (4) @(posedge clock);
      if (faults == 0 && outputs_due.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/jcp_pkg.sv
sv/jcp_csr.sv
sv/jcp_engine.sv
sv/jcp_out_reg.sv
sv/joybus_controller_poller.sv
dv/tb.sv
